FILE: rtl/core/dswd_pkg.sv
`timescale 1ns / 1ps

package dswd_pkg;

  // Field widths
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned COUNT_W = 8;
  localparam int unsigned IDX_W   = 2;

  // Stream payload widths, tdata padded to whole bytes
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 24;
  localparam int unsigned OUT_TUSER_W = 2;

  // Register reset values
  localparam logic [CFG_W-1:0]   TIMEOUT_RST  = 16'd60;
  localparam logic [CFG_W-1:0]   INTERVAL_RST = 16'd10;
  localparam logic [COUNT_W-1:0] REQUIRED_RST = 8'd4;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 8'd255;

  // Register indexes on the configuration port
  typedef enum logic [IDX_W-1:0] {
    CFG_TIMEOUT  = 2'd0,
    CFG_INTERVAL = 2'd1,
    CFG_REQUIRED = 2'd2
  } cfg_idx_t;

  // Event code carried with each result
  typedef enum logic [1:0] {
    EVT_NONE    = 2'd0,
    EVT_START   = 2'd1,
    EVT_TIMEOUT = 2'd2,
    EVT_BOTH    = 2'd3
  } evt_t;

endpackage

FILE: rtl/core/dual_sensor_windowed_debounce.sv
`timescale 1ns / 1ps

// Channel | Dir | Fields (lowest bit first)
// --------+-----+--------------------------------------------------------------
// in_     | in  | tdata: now_seconds[31:0], sens1_trig[32], sens2_trig[33]
// out_    | out | tuser: event_res[1:0]; tdata: sensor1_done_now, sensor2_done_now,
//         |     |   sensor1_ok, sensor2_ok, window_active, count1[12:5], count2[20:13]
// cfg_    | in  | wr_en, index (0 timeout, 1 interval, 2 required count), wdata
//
// One poll per cycle. A transfer on in_ updates the window state and loads the
// result register in the same edge; the result appears in the next cycle.
// The single result register sets the rate: in_tready is high while it is
// empty or being drained, so polls stream back to back under no stall.
// rst_n is synchronous: it closes the window and restores register defaults.
// A stalled out_ holds the result and back-pressures in_ without loss.

module dual_sensor_windowed_debounce
  import dswd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  // configuration write port
  input  logic                   cfg_wr_en,
  input  logic [IDX_W-1:0]       cfg_index,
  input  logic [CFG_W-1:0]       cfg_wdata,
  // poll stream
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // now_seconds, sens1_trig, sens2_trig, pad
  // result stream
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // done1, done2, ok1, ok2, active, count1,
                                             // count2, pad
  output logic [OUT_TUSER_W-1:0] out_tuser   // event_res
);

  // Configuration registers
  logic [CFG_W-1:0]   timeout_r;
  logic [CFG_W-1:0]   interval_r;
  logic [COUNT_W-1:0] required_r;

  // Window state
  logic               active_r,      active_nxt;
  logic [TIME_W-1:0]  win_start_r,   win_start_nxt;
  logic [1:0]         seen_r,        seen_nxt;
  logic [1:0]         qual_r,        qual_nxt;
  logic [COUNT_W-1:0] cnt_r [2];
  logic [COUNT_W-1:0] cnt_nxt [2];
  logic [TIME_W-1:0]  last_r [2];
  logic [TIME_W-1:0]  last_nxt [2];

  // Result register
  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;
  logic [OUT_TUSER_W-1:0] out_user_r;
  evt_t                   evt_nxt;

  // Poll fields and derived terms
  logic [TIME_W-1:0] now;
  logic [1:0]        lvl;
  logic [1:0]        done_nxt, ok_nxt;
  logic [TIME_W-1:0] win_age;
  logic [TIME_W-1:0] samp_age [2];
  logic              in_xfer;

  assign now = in_tdata[TIME_W-1:0];
  assign lvl = in_tdata[TIME_W+1:TIME_W];

  // Accept a poll whenever the result register is free or being drained
  assign in_tready = !out_valid_r || out_tready;
  assign in_xfer   = in_tvalid && in_tready;

  assign win_age = now - win_start_r;

  always_comb begin
    active_nxt    = active_r;
    win_start_nxt = win_start_r;
    seen_nxt      = seen_r;
    qual_nxt      = qual_r;
    evt_nxt       = EVT_NONE;
    done_nxt      = 2'b00;
    ok_nxt        = 2'b00;
    for (int i = 0; i < 2; i++) begin
      cnt_nxt[i]  = cnt_r[i];
      last_nxt[i] = last_r[i];
      samp_age[i] = now - last_r[i];
    end

    if (!active_r) begin
      // Open the window on the first high trigger; nothing else is checked this poll
      if (lvl != 2'b00) begin
        active_nxt    = 1'b1;
        win_start_nxt = now;
        evt_nxt       = EVT_START;
        for (int i = 0; i < 2; i++) begin
          if (lvl[i]) begin
            seen_nxt[i] = 1'b1;
            cnt_nxt[i]  = COUNT_W'(1);
            last_nxt[i] = now;
          end
        end
      end
    end else if (win_age >= {{(TIME_W-CFG_W){1'b0}}, timeout_r}) begin
      // Timeout takes priority over the both-qualified close
      evt_nxt       = EVT_TIMEOUT;
      ok_nxt        = qual_r;
      active_nxt    = 1'b0;
      win_start_nxt = '0;
      seen_nxt      = 2'b00;
      qual_nxt      = 2'b00;
      for (int i = 0; i < 2; i++) begin
        cnt_nxt[i]  = '0;
        last_nxt[i] = '0;
      end
    end else if (qual_r == 2'b11) begin
      evt_nxt       = EVT_BOTH;
      active_nxt    = 1'b0;
      win_start_nxt = '0;
      seen_nxt      = 2'b00;
      qual_nxt      = 2'b00;
      for (int i = 0; i < 2; i++) begin
        cnt_nxt[i]  = '0;
        last_nxt[i] = '0;
      end
    end else begin
      // Sample each unqualified sensor at most once per interval
      for (int i = 0; i < 2; i++) begin
        if (!qual_r[i]) begin
          if (!seen_r[i]) begin
            if (lvl[i]) begin
              seen_nxt[i] = 1'b1;
              cnt_nxt[i]  = COUNT_W'(1);
              last_nxt[i] = now;
            end
          end else if (samp_age[i] >= {{(TIME_W-CFG_W){1'b0}}, interval_r}) begin
            last_nxt[i] = now;
            if (lvl[i]) begin
              // Saturate at the count limit
              cnt_nxt[i] = (cnt_r[i] == COUNT_MAX) ? COUNT_MAX : cnt_r[i] + COUNT_W'(1);
              if (cnt_nxt[i] >= required_r) begin
                qual_nxt[i] = 1'b1;
                done_nxt[i] = 1'b1;
              end
            end else begin
              cnt_nxt[i] = '0;
            end
          end
        end
      end
    end

    out_data_nxt = {3'b000, cnt_nxt[1], cnt_nxt[0], active_nxt,
                    ok_nxt[1], ok_nxt[0], done_nxt[1], done_nxt[0]};
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r  <= TIMEOUT_RST;
      interval_r <= INTERVAL_RST;
      required_r <= REQUIRED_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_TIMEOUT:  timeout_r  <= cfg_wdata;
        CFG_INTERVAL: interval_r <= cfg_wdata;
        CFG_REQUIRED: required_r <= cfg_wdata[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Window state: advance on each poll transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      win_start_r <= '0;
      seen_r      <= 2'b00;
      qual_r      <= 2'b00;
      for (int i = 0; i < 2; i++) begin
        cnt_r[i]  <= '0;
        last_r[i] <= '0;
      end
    end else if (in_xfer) begin
      active_r    <= active_nxt;
      win_start_r <= win_start_nxt;
      seen_r      <= seen_nxt;
      qual_r      <= qual_nxt;
      for (int i = 0; i < 2; i++) begin
        cnt_r[i]  <= cnt_nxt[i];
        last_r[i] <= last_nxt[i];
      end
    end
  end

  // Result register: load on poll transfer, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_xfer) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_data_r <= out_data_nxt;
      out_user_r <= evt_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule
